### hdl/qtu_pkg.sv
package qtu_pkg;

  // Table geometry
  localparam int STATE_BITS  = 6;
  localparam int ACTION_BITS = 3;
  localparam int MAX_ACTIONS = 1 << ACTION_BITS;
  localparam int ADDR_BITS   = STATE_BITS + ACTION_BITS;
  localparam int COUNT_BITS  = ACTION_BITS + 1;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam int          RATE_BITS = 17;

  // Configuration register indexes
  localparam int                  CFG_INDEX_BITS  = 2;
  localparam int                  CFG_DATA_BITS   = 17;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEARN_RATE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISCOUNT     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTION_COUNT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [16:0]           LEARN_RATE_RESET   = 17'd6554;
  localparam logic [16:0]           DISCOUNT_RESET     = 17'd32768;
  localparam logic [COUNT_BITS-1:0] ACTION_COUNT_RESET = 4'd8;

  typedef struct packed {
    logic [STATE_BITS-1:0]  state_index;
    logic [ACTION_BITS-1:0] action_index;
    logic signed [31:0]     reward;
    logic [STATE_BITS-1:0]  next_state_index;
  } qtu_req_t;

  typedef struct packed {
    logic signed [31:0]     new_q;
    logic [30:0]            best_next_q;
    logic [ACTION_BITS-1:0] best_next_action;
  } qtu_rsp_t;

endpackage

### hdl/q_table_update.sv
// Tabular Q-learning update engine. Each request carries one transition
// (state, action, reward, next state); the engine scans the next state's row
// of a 64 x 8 Q16.16 table held in a single-port-read, single-port-write
// synchronous RAM, finds the best value floored at zero (first action wins on
// ties, action 0 when nothing is positive), then writes back
// q' = (1-alpha)*q + alpha*(reward + gamma*maxQ) with round-half-up and 32-bit
// saturation, and returns the new value with the best value and action.
// The row scan covers the first n entries of the row, where n is action_count
// capped at 8: it issues one RAM read per cycle on the single read port,
// followed by the current entry's read and a short multiply/round pipeline.
// A new request is taken in the cycle after the write-back, even while the
// previous result is still waiting. After reset the engine zeroes all 512 RAM
// entries, one entry per cycle, before it accepts its first request;
// configuration writes are taken at any time and should only be issued while
// the engine is idle.
module q_table_update
  import qtu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  qtu_req_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output qtu_rsp_t                  out_data
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_QWAIT  = 3'd3;
  localparam logic [2:0] ST_TSUM   = 3'd4;
  localparam logic [2:0] ST_MULB   = 3'd5;
  localparam logic [2:0] ST_SUM    = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] st;

  // Configuration registers
  logic [RATE_BITS-1:0]  learn_rate;
  logic [RATE_BITS-1:0]  discount;
  logic [COUNT_BITS-1:0] action_count;

  // Request and scan state
  qtu_req_t               req;
  logic [COUNT_BITS-1:0]  scan_n;
  logic [COUNT_BITS-1:0]  scan_idx;
  logic                   pend;
  logic [ACTION_BITS-1:0] pend_idx;
  logic [30:0]            best;
  logic [ACTION_BITS-1:0] best_act;
  logic [ADDR_BITS-1:0]   clr_addr;

  // Arithmetic pipeline
  logic signed [31:0] q_old;
  logic [47:0]        gprod;
  logic signed [33:0] t_val;
  logic signed [49:0] p1;
  logic signed [50:0] p2;
  logic signed [52:0] acc;

  // RAM
  logic [31:0]          mem [0:(1 << ADDR_BITS)-1];
  logic [31:0]          rdata;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [31:0]          mem_wdata;

  // Combinational helpers
  logic                   in_acc;
  logic                   out_free;
  logic [RATE_BITS-1:0]   alpha;
  logic [RATE_BITS-1:0]   gamma;
  logic [RATE_BITS-1:0]   om_alpha;
  logic [COUNT_BITS-1:0]  cnt_cap;
  logic                   scan_more;
  logic                   scan_hit;
  logic [32:0]            gb;
  logic signed [36:0]     nq_full;
  logic signed [31:0]     nq;

  assign in_ready  = (st == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign alpha     = (learn_rate > RATE_BITS'(ONE_Q16)) ? ONE_Q16 : learn_rate;
  assign gamma     = (discount > RATE_BITS'(ONE_Q16)) ? ONE_Q16 : discount;
  assign om_alpha  = ONE_Q16 - alpha;
  assign cnt_cap   = (action_count > COUNT_BITS'(MAX_ACTIONS)) ?
                     COUNT_BITS'(MAX_ACTIONS) : action_count;
  assign scan_more = (scan_idx < scan_n);
  assign scan_hit  = pend && !rdata[31] && (rdata[30:0] > best);

  // Round gamma * best to Q16.16, ties upward
  assign gb = 33'((gprod + 48'd32768) >> 16);

  // Round the sum and saturate to 32 bits
  assign nq_full = 37'(acc >>> 16);
  always_comb begin
    if (nq_full[36:31] == {6{nq_full[31]}}) begin
      nq = nq_full[31:0];
    end else if (nq_full[36]) begin
      nq = 32'sh8000_0000;
    end else begin
      nq = 32'sh7FFF_FFFF;
    end
  end

  // Pick read and write ports
  always_comb begin
    if (st == ST_SCAN && scan_more) begin
      mem_raddr = {req.next_state_index, scan_idx[ACTION_BITS-1:0]};
    end else begin
      mem_raddr = {req.state_index, req.action_index};
    end
    mem_we    = (st == ST_CLEAR) || (st == ST_FINISH && out_free);
    mem_waddr = (st == ST_CLEAR) ? clr_addr : {req.state_index, req.action_index};
    mem_wdata = (st == ST_CLEAR) ? 32'd0 : nq;
  end

  // Table RAM with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate   <= LEARN_RATE_RESET;
      discount     <= DISCOUNT_RESET;
      action_count <= ACTION_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE:   learn_rate   <= cfg_data;
        REG_DISCOUNT:     discount     <= cfg_data;
        REG_ACTION_COUNT: action_count <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise the result on write-back, drop it once taken
      if (st == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            pend     <= 1'b0;
            scan_idx <= '0;
            st       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            pend     <= 1'b1;
            pend_idx <= scan_idx[ACTION_BITS-1:0];
            scan_idx <= scan_idx + 1'b1;
          end else begin
            pend <= 1'b0;
            st   <= ST_QWAIT;
          end
        end
        ST_QWAIT:  st <= ST_TSUM;
        ST_TSUM:   st <= ST_MULB;
        ST_MULB:   st <= ST_SUM;
        ST_SUM:    st <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req      <= in_data;
      scan_n   <= cnt_cap;
      best     <= '0;
      best_act <= '0;
    end else if (scan_hit) begin
      best     <= rdata[30:0];
      best_act <= pend_idx;
    end
    if (st == ST_QWAIT) begin
      q_old <= rdata;
      gprod <= gamma * {1'b0, best};
    end
    if (st == ST_TSUM) begin
      t_val <= $signed({{2{req.reward[31]}}, req.reward} + {1'b0, gb});
      p1    <= $signed({1'b0, om_alpha}) * q_old;
    end
    if (st == ST_MULB) begin
      p2 <= $signed({1'b0, alpha}) * t_val;
    end
    if (st == ST_SUM) begin
      acc <= p1 + p2 + 53'sd32768;
    end
    if (st == ST_FINISH && out_free) begin
      out_data.new_q            <= nq;
      out_data.best_next_q      <= best;
      out_data.best_next_action <= best_act;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> st == ST_SCAN)
    else $error("accepted request did not start a row scan");

  a_write_only_clear_or_finish: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (st == ST_CLEAR || st == ST_FINISH))
    else $error("table written outside clear or write-back");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st) == ST_FINISH)
    else $error("result raised without a write-back");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (rst)
    st == ST_SCAN |-> (scan_idx <= scan_n && scan_n <= COUNT_BITS'(MAX_ACTIONS)))
    else $error("row scan index out of range");

  a_best_action_in_range: assert property (@(posedge clk) disable iff (rst)
    st == ST_QWAIT |-> (best_act < scan_n || best_act == '0))
    else $error("best action beyond scanned entries");
`endif

endmodule

### verif/tb_q_table_update.sv
`timescale 1ns / 1ps

module tb_q_table_update;
  import qtu_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int TABLE_DEPTH = (1 << STATE_BITS) * MAX_ACTIONS;
  localparam logic signed [31:0] REWARD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] REWARD_MIN = 32'sh8000_0000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  qtu_req_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  qtu_rsp_t                  out_data;

  q_table_update uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Mirror of the Q table and the registers
  logic signed [31:0]      q_model [TABLE_DEPTH];
  logic [RATE_BITS-1:0]    rate_alpha = LEARN_RATE_RESET;
  logic [RATE_BITS-1:0]    rate_gamma = DISCOUNT_RESET;
  logic [COUNT_BITS-1:0]   scan_count = ACTION_COUNT_RESET;

  qtu_req_t pending_reqs [$];
  qtu_rsp_t expected_rsps [$];
  qtu_rsp_t want_rsp;

  int send_idle_pct = 15;
  int recv_idle_pct = 64;
  int err_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int cfg_count = 0;
  int stall_cycles = 0;

  initial begin
    for (int k = 0; k < TABLE_DEPTH; k++) q_model[k] = '0;
  end

  // Divide by 2^16, round to nearest with ties upward
  function automatic longint round_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  // Scan the next row, then update the current entry
  function automatic qtu_rsp_t apply_update(qtu_req_t req);
    qtu_rsp_t rsp;
    int n;
    int row;
    int addr;
    longint alpha, gamma, best, cur, t, nq;
    logic [ACTION_BITS-1:0] best_act;
    n = (scan_count > MAX_ACTIONS) ? MAX_ACTIONS : int'(scan_count);
    alpha = (rate_alpha > ONE_Q16) ? longint'(ONE_Q16) : longint'(rate_alpha);
    gamma = (rate_gamma > ONE_Q16) ? longint'(ONE_Q16) : longint'(rate_gamma);
    row = int'(req.next_state_index) * MAX_ACTIONS;
    best = 0;
    best_act = '0;
    for (int i = 0; i < n; i++) begin
      if (longint'(q_model[row + i]) > best) begin
        best = longint'(q_model[row + i]);
        best_act = i[ACTION_BITS-1:0];
      end
    end
    addr = int'(req.state_index) * MAX_ACTIONS + int'(req.action_index);
    cur = longint'(q_model[addr]);
    t = longint'(req.reward) + round_q16(gamma * best);
    nq = round_q16((longint'(ONE_Q16) - alpha) * cur + alpha * t);
    if (nq > 64'sd2147483647) nq = 64'sd2147483647;
    if (nq < -64'sd2147483648) nq = -64'sd2147483648;
    q_model[addr] = nq[31:0];
    rsp.new_q = nq[31:0];
    rsp.best_next_q = best[30:0];
    rsp.best_next_action = best_act;
    return rsp;
  endfunction

  function automatic qtu_req_t mk_req(int s, int a, logic signed [31:0] r, int ns);
    qtu_req_t req;
    req.state_index = s[STATE_BITS-1:0];
    req.action_index = a[ACTION_BITS-1:0];
    req.reward = r;
    req.next_state_index = ns[STATE_BITS-1:0];
    return req;
  endfunction

  // Drive the request channel
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(apply_update(in_data));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Accept and check results
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected, expected none, got %0h", $time,
                   out_data);
        end else begin
          want_rsp = expected_rsps.pop_front();
          check_field("new_q", want_rsp.new_q, out_data.new_q);
          check_field("best_next_q", {1'b0, want_rsp.best_next_q},
                      {1'b0, out_data.best_next_q});
          check_field("best_next_action", {29'd0, want_rsp.best_next_action},
                      {29'd0, out_data.best_next_action});
          checked_count++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LEARN_RATE: rate_alpha = val;
      REG_DISCOUNT: rate_gamma = val;
      REG_ACTION_COUNT: scan_count = val[COUNT_BITS-1:0];
      default: ;
    endcase
    cfg_count++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample between edges so the driver and monitor have settled
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ONE_Q16;
      2: return '1;
      3: return CFG_DATA_BITS'($urandom_range(65537, 131070));
      default: return CFG_DATA_BITS'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_DATA_BITS'(1);
      2, 3: return CFG_DATA_BITS'(MAX_ACTIONS);
      4: return CFG_DATA_BITS'($urandom_range(9, 15));
      default: return CFG_DATA_BITS'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int hot_state();
    return $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(58, 63);
  endfunction

  // Mostly short episodes over a few states, plus wide and extreme noise
  task automatic queue_random(int count);
    int n;
    int kind;
    logic signed [31:0] r;
    n = (scan_count == 0) ? MAX_ACTIONS :
        (scan_count > MAX_ACTIONS) ? MAX_ACTIONS : int'(scan_count);
    @(negedge clk);
    repeat (count) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        r = $urandom_range(0, 32'h0004_0000) - 32'sh0002_0000;
        pending_reqs.push_back(mk_req(hot_state(), $urandom_range(0, n - 1), r,
                                      hot_state()));
      end else if (kind < 85) begin
        r = $urandom_range(0, 32'h0200_0000) - 32'sh0100_0000;
        pending_reqs.push_back(mk_req($urandom_range(0, 63), $urandom_range(0, 7), r,
                                      $urandom_range(0, 63)));
      end else if (kind < 95) begin
        pending_reqs.push_back(mk_req($urandom_range(0, 63), $urandom_range(0, 7),
                                      $urandom, $urandom_range(0, 63)));
      end else begin
        r = $urandom_range(0, 1) ? REWARD_MAX : REWARD_MIN;
        pending_reqs.push_back(mk_req($urandom_range(0, 1) ? 63 : 0, $urandom_range(0, 7),
                                      r, $urandom_range(0, 1) ? 63 : hot_state()));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extremes, then the same row read and written twice
    @(negedge clk);
    pending_reqs.push_back(mk_req(0, 0, 0, 0));
    pending_reqs.push_back(mk_req(63, 7, REWARD_MAX, 63));
    pending_reqs.push_back(mk_req(1, 3, REWARD_MIN, 63));
    pending_reqs.push_back(mk_req(5, 2, 32'sh0001_0000, 5));
    pending_reqs.push_back(mk_req(5, 2, 32'sh0001_0000, 5));
    wait_drained();

    // Full learning rate, no discount: load exact values, check tie-break
    write_reg(REG_LEARN_RATE, ONE_Q16);
    write_reg(REG_DISCOUNT, '0);
    @(negedge clk);
    pending_reqs.push_back(mk_req(10, 2, 1000, 0));
    pending_reqs.push_back(mk_req(10, 5, 1000, 0));
    pending_reqs.push_back(mk_req(10, 1, -5, 0));
    pending_reqs.push_back(mk_req(11, 0, 0, 10));
    pending_reqs.push_back(mk_req(10, 7, REWARD_MAX, 10));
    wait_drained();

    // Rates above one saturate; push the sum past the positive limit
    write_reg(REG_LEARN_RATE, '1);
    write_reg(REG_DISCOUNT, 17'd65537);
    @(negedge clk);
    pending_reqs.push_back(mk_req(12, 3, REWARD_MAX, 10));
    pending_reqs.push_back(mk_req(12, 4, REWARD_MIN, 12));
    wait_drained();

    // Empty scan
    write_reg(REG_ACTION_COUNT, '0);
    @(negedge clk);
    pending_reqs.push_back(mk_req(13, 1, 32'sh0002_0000, 10));
    wait_drained();

    // Action outside the scanned range is still updated
    write_reg(REG_ACTION_COUNT, CFG_DATA_BITS'(3));
    @(negedge clk);
    pending_reqs.push_back(mk_req(10, 6, 0, 10));
    wait_drained();

    // Oversized count caps at the row width; unused index is ignored
    write_reg(REG_ACTION_COUNT, CFG_DATA_BITS'(15));
    write_reg(REG_UNUSED, '1);
    @(negedge clk);
    pending_reqs.push_back(mk_req(14, 0, 0, 10));
    wait_drained();

    // Zero learning rate leaves the entry as it was
    write_reg(REG_ACTION_COUNT, CFG_DATA_BITS'(1));
    write_reg(REG_LEARN_RATE, '0);
    write_reg(REG_DISCOUNT, ONE_Q16);
    @(negedge clk);
    pending_reqs.push_back(mk_req(15, 7, REWARD_MAX, 10));
    pending_reqs.push_back(mk_req(62, 5, REWARD_MIN, 10));

    // Random phases under the three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      @(negedge clk);
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 15 : 0;
      for (int b = 0; b < 4; b++) begin
        wait_drained();
        write_reg(REG_LEARN_RATE, pick_rate());
        write_reg(REG_DISCOUNT, pick_rate());
        write_reg(REG_ACTION_COUNT, pick_count());
        queue_random(140);
      end
    end

    // Let the last update settle
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Covered %0d transitions and %0d checked results under %0d register writes",
             sent_count, checked_count, cfg_count);
    $display("Saw %0d mismatches, %0d results still outstanding", err_count,
             expected_rsps.size());
    if (err_count == 0 && expected_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/qtu_pkg.sv
hdl/q_table_update.sv
verif/tb_q_table_update.sv
